[hdl/spre_pkg.sv]
// ----------------------------------------------------------------------------
// spre_pkg
// Shared constants, codes and types of the shortest-path row engine.
// ----------------------------------------------------------------------------
package spre_pkg;

  localparam int MaxNodes     = 256;
  localparam int MaxEdges     = 1024;
  localparam int FractionBits = 4;

  localparam int NODE_AW  = $clog2(MaxNodes);
  localparam int EDGE_AW  = $clog2(MaxEdges);
  localparam int ECNT_W   = EDGE_AW + 1;
  localparam int NCNT_W   = NODE_AW + 1;
  localparam int LEN_W    = 24;
  localparam int DIST_W   = 36;
  localparam int ROW_W    = 32;
  localparam int EDGE_W   = LEN_W + 2 * NODE_AW;

  localparam logic [ECNT_W-1:0] EDGE_FULL = ECNT_W'(MaxEdges);
  localparam logic [NCNT_W-1:0] NODE_END  = NCNT_W'(MaxNodes);
  localparam logic [DIST_W-1:0] HALF      = DIST_W'(1) << (FractionBits - 1);
  localparam logic [DIST_W-1:0] LIMIT_NARROW = DIST_W'(64'h0000_FFFF) << FractionBits;
  localparam logic [DIST_W-1:0] LIMIT_WIDE   = DIST_W'(64'hFFFF_FFFF) << FractionBits;

  typedef enum logic [1:0] {
    ACT_ADD  = 2'd0,
    ACT_SRCH = 2'd1,
    ACT_READ = 2'd2,
    ACT_NONE = 2'd3
  } action_t;

  typedef enum logic [2:0] {
    ST_OK        = 3'd0,
    ST_OVERFLOW  = 3'd1,
    ST_MISSING   = 3'd2,
    ST_NOT_POINT = 3'd3,
    ST_FULL      = 3'd4
  } status_t;

  typedef enum logic [14:0] {
    S_IDLE     = 15'h0001,
    S_ADD_RD   = 15'h0002,
    S_ADD_CMP  = 15'h0004,
    S_ADD_PUT  = 15'h0008,
    S_SRCH     = 15'h0010,
    S_HO_RD    = 15'h0020,
    S_HO_CMP   = 15'h0040,
    S_MIN      = 15'h0080,
    S_SETTLE   = 15'h0100,
    S_REL_RD   = 15'h0200,
    S_REL_EDGE = 15'h0400,
    S_REL_DIST = 15'h0800,
    S_READ     = 15'h1000,
    S_RWAIT    = 15'h2000,
    S_DONE     = 15'h4000
  } state_t;

  localparam logic [2:0] ADDR_POINT_COUNT = 3'd0;
  localparam logic [2:0] ADDR_NARROW      = 3'd4;

endpackage

[hdl/shortest_path_row_engine.sv]
// ----------------------------------------------------------------------------
// shortest_path_row_engine
// Dijkstra search over a stored directed graph with a per-node result row.
// ----------------------------------------------------------------------------
// Operation: add edge scans the stored edges, one lookup at a time through
//   the edge RAM; read distance fetches one row word; a search makes a
//   source pass over all stored edges, then per settled node a minimum scan
//   over the distance RAM and a relaxation pass over the stored edges.
// Throughput: one word at a time; the next word is taken once the current
//   one is finished, even while its result still waits at the output.
// Reset: clears edge count, flags, control and registers (point_count 256,
//   narrow_output 0); RAM contents are not cleared.
// ----------------------------------------------------------------------------
module shortest_path_row_engine (
  input  logic        clk,
  input  logic        rst,
  // input word
  input  logic        s_tvalid,
  output logic        s_tready,
  input  logic [47:0] s_tdata,   // action[1:0], node_a[9:2], node_b[17:10], weight[41:18]
  // result word
  output logic        m_tvalid,
  input  logic        m_tready,
  output logic [39:0] m_tdata,   // status[2:0], distance[34:3], written[35]
  // configuration
  input  logic        psel,
  input  logic        penable,
  input  logic        pwrite,
  input  logic [2:0]  paddr,
  input  logic [31:0] pwdata,
  output logic [31:0] prdata,
  output logic        pready
);

  localparam int NA = spre_pkg::NODE_AW;
  localparam int EA = spre_pkg::EDGE_AW;
  localparam int EW = spre_pkg::EDGE_W;
  localparam int DW = spre_pkg::DIST_W;
  localparam int RW = spre_pkg::ROW_W;

  // Configuration registers
  logic [8:0] point_count;
  logic       narrow_output;

  assign pready = 1'b1;

  always_ff @(posedge clk) begin
    if (rst) begin
      point_count   <= 9'd256;
      narrow_output <= 1'b0;
    end else if (psel && penable && pwrite) begin
      if (paddr[2]) begin
        narrow_output <= pwdata[0];
      end else begin
        point_count <= pwdata[8:0];
      end
    end
  end

  always_comb begin
    if (paddr == spre_pkg::ADDR_NARROW) begin
      prdata = {31'd0, narrow_output};
    end else if (paddr == spre_pkg::ADDR_POINT_COUNT) begin
      prdata = {23'd0, point_count};
    end else begin
      prdata = 32'd0;
    end
  end

  // Input word fields
  logic [1:0]  in_action;
  logic [NA-1:0] in_a, in_b;
  logic [23:0] in_w;
  assign in_action = s_tdata[1:0];
  assign in_a      = s_tdata[9:2];
  assign in_b      = s_tdata[17:10];
  assign in_w      = s_tdata[41:18];

  spre_pkg::state_t state;

  // Held copy of the word under work
  logic [NA-1:0] op_a, op_b;
  logic [23:0]   op_w;

  logic [spre_pkg::ECNT_W-1:0] edge_count;
  logic [spre_pkg::ECNT_W-1:0] idx;

  logic [spre_pkg::MaxNodes-1:0] has_out, seen, settled;
  logic [spre_pkg::NCNT_W-1:0]   npoints, found;

  // Minimum scan
  logic [spre_pkg::NCNT_W-1:0] scan_n;
  logic          chk_v;
  logic [NA-1:0] chk_n;
  logic          any;
  logic [NA-1:0] best_n;
  logic [DW-1:0] best_d;

  // Relaxation
  logic [NA-1:0] cur;
  logic [DW-1:0] cur_d;
  logic [NA-1:0] rel_t;
  logic [DW-1:0] rel_d;

  // Result held until the output register frees up
  logic [2:0]    res_status;
  logic [RW-1:0] res_dist;
  logic          res_wr;

  logic          out_valid;
  logic [39:0]   out_data;

  // Memories
  logic          e_we;
  logic [EA-1:0] e_waddr, e_raddr;
  logic [EW-1:0] e_wdata, e_rdata;
  logic          d_we;
  logic [NA-1:0] d_waddr, d_raddr;
  logic [DW-1:0] d_wdata, d_rdata;
  logic          r_we;
  logic [NA-1:0] r_waddr, r_raddr;
  logic [RW-1:0] r_wdata, r_rdata;

  spre_ram #(.WIDTH(EW), .DEPTH(spre_pkg::MaxEdges)) u_edge_ram (
    .clk, .we(e_we), .waddr(e_waddr), .wdata(e_wdata), .raddr(e_raddr), .rdata(e_rdata)
  );
  spre_ram #(.WIDTH(DW), .DEPTH(spre_pkg::MaxNodes)) u_dist_ram (
    .clk, .we(d_we), .waddr(d_waddr), .wdata(d_wdata), .raddr(d_raddr), .rdata(d_rdata)
  );
  spre_ram #(.WIDTH(RW), .DEPTH(spre_pkg::MaxNodes)) u_row_ram (
    .clk, .we(r_we), .waddr(r_waddr), .wdata(r_wdata), .raddr(r_raddr), .rdata(r_rdata)
  );

  // Edge word fields: source low, target, then length
  logic [NA-1:0] e_src, e_tgt;
  logic [23:0]   e_len;
  assign e_src = e_rdata[NA-1:0];
  assign e_tgt = e_rdata[2*NA-1:NA];
  assign e_len = e_rdata[EW-1:2*NA];

  // Settle-step arithmetic
  logic [DW-1:0] raw_limit;
  logic [DW-1:0] rounded;
  logic          cur_is_point;
  logic [spre_pkg::NCNT_W-1:0] found_next;
  logic [DW-1:0] nd;
  logic          better;

  assign raw_limit    = narrow_output ? spre_pkg::LIMIT_NARROW : spre_pkg::LIMIT_WIDE;
  assign rounded      = best_d + spre_pkg::HALF;
  assign cur_is_point = {1'b0, best_n} < point_count;
  assign found_next   = found + (cur_is_point ? 9'd1 : 9'd0);
  assign nd           = cur_d + DW'(e_len);
  assign better       = !any || (d_rdata < best_d);

  assign s_tready = (state == spre_pkg::S_IDLE);

  // Memory port steering
  always_comb begin
    e_we    = 1'b0;
    e_waddr = idx[EA-1:0];
    e_wdata = {op_w, op_b, op_a};
    e_raddr = idx[EA-1:0];
    d_we    = 1'b0;
    d_waddr = rel_t;
    d_wdata = rel_d;
    d_raddr = scan_n[NA-1:0];
    r_we    = 1'b0;
    r_waddr = best_n;
    r_wdata = rounded[DW-1:spre_pkg::FractionBits];
    r_raddr = op_b;
    case (state)
      spre_pkg::S_ADD_CMP: begin
        // overwrite the length of a stored pair in place
        e_we = (e_src == op_a) && (e_tgt == op_b);
      end
      spre_pkg::S_ADD_PUT: begin
        e_we = (edge_count != spre_pkg::EDGE_FULL);
        e_waddr = edge_count[EA-1:0];
      end
      spre_pkg::S_HO_RD: begin
        // start node enters at distance zero
        d_we    = (idx == edge_count);
        d_waddr = op_a;
        d_wdata = '0;
      end
      spre_pkg::S_SETTLE: begin
        r_we = any && cur_is_point && !(best_d > raw_limit);
      end
      spre_pkg::S_REL_EDGE: begin
        d_raddr = e_tgt;
      end
      spre_pkg::S_REL_DIST: begin
        d_we = !seen[rel_t] || (!settled[rel_t] && (rel_d < d_rdata));
      end
      default: begin
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state      <= spre_pkg::S_IDLE;
      edge_count <= '0;
      has_out    <= '0;
      seen       <= '0;
      settled    <= '0;
      out_valid  <= 1'b0;
      chk_v      <= 1'b0;
    end else begin
      // drop the taken word unless a new one is loaded this cycle
      if (m_tready && (state != spre_pkg::S_DONE)) begin
        out_valid <= 1'b0;
      end
      case (state)
        spre_pkg::S_IDLE: begin
          if (s_tvalid) begin
            op_a       <= in_a;
            op_b       <= in_b;
            op_w       <= in_w;
            idx        <= '0;
            res_status <= spre_pkg::ST_OK;
            res_dist   <= '0;
            res_wr     <= 1'b0;
            case (in_action)
              spre_pkg::ACT_ADD:  state <= spre_pkg::S_ADD_RD;
              spre_pkg::ACT_SRCH: state <= spre_pkg::S_SRCH;
              spre_pkg::ACT_READ: state <= spre_pkg::S_READ;
              default:            state <= spre_pkg::S_DONE;
            endcase
          end
        end
        spre_pkg::S_ADD_RD: begin
          state <= (idx == edge_count) ? spre_pkg::S_ADD_PUT : spre_pkg::S_ADD_CMP;
        end
        spre_pkg::S_ADD_CMP: begin
          if ((e_src == op_a) && (e_tgt == op_b)) begin
            state <= spre_pkg::S_DONE;
          end else begin
            idx   <= idx + 1'b1;
            state <= spre_pkg::S_ADD_RD;
          end
        end
        spre_pkg::S_ADD_PUT: begin
          if (edge_count == spre_pkg::EDGE_FULL) begin
            res_status <= spre_pkg::ST_FULL;
          end else begin
            edge_count <= edge_count + 1'b1;
          end
          state <= spre_pkg::S_DONE;
        end
        spre_pkg::S_SRCH: begin
          if ({1'b0, op_a} >= point_count) begin
            // previous search stays readable
            res_status <= spre_pkg::ST_NOT_POINT;
            state      <= spre_pkg::S_DONE;
          end else begin
            has_out <= '0;
            seen    <= '0;
            settled <= '0;
            npoints <= '0;
            found   <= '0;
            state   <= spre_pkg::S_HO_RD;
          end
        end
        spre_pkg::S_HO_RD: begin
          if (idx == edge_count) begin
            seen[op_a] <= 1'b1;
            scan_n     <= '0;
            chk_v      <= 1'b0;
            any        <= 1'b0;
            state      <= spre_pkg::S_MIN;
          end else begin
            state <= spre_pkg::S_HO_CMP;
          end
        end
        spre_pkg::S_HO_CMP: begin
          // count each point node with outgoing edges once
          if (!has_out[e_src]) begin
            has_out[e_src] <= 1'b1;
            if ({1'b0, e_src} < point_count) begin
              npoints <= npoints + 1'b1;
            end
          end
          idx   <= idx + 1'b1;
          state <= spre_pkg::S_HO_RD;
        end
        spre_pkg::S_MIN: begin
          // one read issued and one candidate checked per cycle
          if (chk_v && seen[chk_n] && !settled[chk_n] && better) begin
            any    <= 1'b1;
            best_n <= chk_n;
            best_d <= d_rdata;
          end
          if (scan_n != spre_pkg::NODE_END) begin
            chk_v  <= 1'b1;
            chk_n  <= scan_n[NA-1:0];
            scan_n <= scan_n + 1'b1;
          end else begin
            chk_v <= 1'b0;
            if (!chk_v) begin
              state <= spre_pkg::S_SETTLE;
            end
          end
        end
        spre_pkg::S_SETTLE: begin
          if (!any) begin
            res_status <= (found == npoints) ? spre_pkg::ST_OK : spre_pkg::ST_MISSING;
            state      <= spre_pkg::S_DONE;
          end else if (cur_is_point && (best_d > raw_limit)) begin
            res_status <= spre_pkg::ST_OVERFLOW;
            state      <= spre_pkg::S_DONE;
          end else begin
            settled[best_n] <= 1'b1;
            found           <= found_next;
            cur             <= best_n;
            cur_d           <= best_d;
            idx             <= '0;
            state <= (found_next == npoints) ? spre_pkg::S_DONE : spre_pkg::S_REL_RD;
          end
        end
        spre_pkg::S_REL_RD: begin
          if (idx == edge_count) begin
            scan_n <= '0;
            chk_v  <= 1'b0;
            any    <= 1'b0;
            state  <= spre_pkg::S_MIN;
          end else begin
            state <= spre_pkg::S_REL_EDGE;
          end
        end
        spre_pkg::S_REL_EDGE: begin
          if (e_src == cur) begin
            rel_t <= e_tgt;
            rel_d <= nd;
            state <= spre_pkg::S_REL_DIST;
          end else begin
            idx   <= idx + 1'b1;
            state <= spre_pkg::S_REL_RD;
          end
        end
        spre_pkg::S_REL_DIST: begin
          seen[rel_t] <= 1'b1;
          idx         <= idx + 1'b1;
          state       <= spre_pkg::S_REL_RD;
        end
        spre_pkg::S_READ: begin
          state <= spre_pkg::S_RWAIT;
        end
        spre_pkg::S_RWAIT: begin
          if (settled[op_b]) begin
            res_dist <= r_rdata;
            res_wr   <= 1'b1;
          end
          state <= spre_pkg::S_DONE;
        end
        spre_pkg::S_DONE: begin
          // hand over once the output register is free
          if (!out_valid || m_tready) begin
            out_valid <= 1'b1;
            out_data  <= {4'd0, res_wr, res_dist, res_status};
            state     <= spre_pkg::S_IDLE;
          end
        end
        default: begin
          state <= spre_pkg::S_IDLE;
        end
      endcase
    end
  end

  assign m_tvalid = out_valid;
  assign m_tdata  = out_data;

endmodule

[hdl/spre_ram.sv]
// ----------------------------------------------------------------------------
// spre_ram
// Generic simple dual-port RAM: one write port, one read port, registered read.
// ----------------------------------------------------------------------------
module spre_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 256
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule

[bench/tb_shortest_path_row_engine.sv]
// ----------------------------------------------------------------------------
// tb_shortest_path_row_engine
// Self-checking bench for the shortest-path row engine: directed tests of
// edge storage, searches, register settings and overflow, then randomized
// traffic and a long receiver hold. An in-bench predictor tracks the graph
// and the last search; every result word is compared field by field.
// ----------------------------------------------------------------------------
module tb_shortest_path_row_engine;
  timeunit 1ns;
  timeprecision 1ps;

  localparam int IdleLimit = 200000;

  typedef struct {
    spre_pkg::status_t status;
    logic [31:0]       distance;
    logic              written;
  } row_result_t;

  logic        clk, rst;
  logic        s_tvalid, s_tready;
  logic [47:0] s_tdata;   // action[1:0], node_a[9:2], node_b[17:10], weight[41:18]
  logic        m_tvalid, m_tready;
  logic [39:0] m_tdata;   // status[2:0], distance[34:3], written[35]
  logic        psel, penable, pwrite, pready;
  logic [2:0]  paddr;
  logic [31:0] pwdata, prdata;

  shortest_path_row_engine uut (
    .clk(clk), .rst(rst),
    .s_tvalid(s_tvalid), .s_tready(s_tready), .s_tdata(s_tdata),
    .m_tvalid(m_tvalid), .m_tready(m_tready), .m_tdata(m_tdata),
    .psel(psel), .penable(penable), .pwrite(pwrite), .paddr(paddr),
    .pwdata(pwdata), .prdata(prdata), .pready(pready)
  );

  always begin
    clk = 1'b0; #5;
    clk = 1'b1; #5;
  end

  // Predicted engine state: edge table, last search and registers.
  logic [7:0]  graph_src [spre_pkg::MaxEdges];
  logic [7:0]  graph_dst [spre_pkg::MaxEdges];
  logic [23:0] graph_len [spre_pkg::MaxEdges];
  int unsigned graph_edges;
  logic [63:0] path_dist [spre_pkg::MaxNodes];
  bit          node_seen [spre_pkg::MaxNodes];
  bit          node_settled [spre_pkg::MaxNodes];
  logic [31:0] dist_row [spre_pkg::MaxNodes];
  int unsigned point_count;
  bit          narrow;

  row_result_t pending_rows[$];
  int          failures;
  bit          quiet;          // no sender gaps, no random receiver stalls
  int          recv_stall;
  int          recv_hold;
  int          idle_cycles;

  function automatic int find_edge(logic [7:0] a, logic [7:0] b);
    for (int i = 0; i < graph_edges; i++)
      if (graph_src[i] == a && graph_dst[i] == b) return i;
    return -1;
  endfunction

  function automatic spre_pkg::status_t store_edge(logic [7:0] a, logic [7:0] b,
                                                   logic [23:0] w);
    int idx;
    idx = find_edge(a, b);
    if (idx >= 0) begin
      graph_len[idx] = w;
      return spre_pkg::ST_OK;
    end
    if (graph_edges >= spre_pkg::MaxEdges) return spre_pkg::ST_FULL;
    graph_src[graph_edges] = a;
    graph_dst[graph_edges] = b;
    graph_len[graph_edges] = w;
    graph_edges++;
    return spre_pkg::ST_OK;
  endfunction

  // Dijkstra with (distance, id) order; stops once as many points are settled
  // as there are points with outgoing edges.
  function automatic spre_pkg::status_t search_rows(logic [7:0] start);
    bit          has_out [spre_pkg::MaxNodes];
    logic [63:0] raw_limit, d, nd;
    int unsigned need, found, cur;
    bit          any;
    if (start >= point_count) return spre_pkg::ST_NOT_POINT;
    raw_limit = (narrow ? 64'd65535 : 64'hFFFF_FFFF) << spre_pkg::FractionBits;
    need = 0;
    found = 0;
    for (int i = 0; i < spre_pkg::MaxNodes; i++) has_out[i] = 0;
    for (int i = 0; i < graph_edges; i++) has_out[graph_src[i]] = 1;
    for (int i = 0; i < spre_pkg::MaxNodes; i++) begin
      if (i < point_count && has_out[i]) need++;
      node_seen[i] = 0;
      node_settled[i] = 0;
    end
    node_seen[start] = 1;
    path_dist[start] = 0;
    forever begin
      any = 0;
      cur = 0;
      for (int i = 0; i < spre_pkg::MaxNodes; i++)
        if (node_seen[i] && !node_settled[i] && (!any || path_dist[i] < path_dist[cur])) begin
          cur = i;
          any = 1;
        end
      if (!any) break;
      d = path_dist[cur];
      if (cur < point_count) begin
        if (d > raw_limit) return spre_pkg::ST_OVERFLOW;
        dist_row[cur] = 32'((d + 64'(1 << (spre_pkg::FractionBits - 1)))
                            >> spre_pkg::FractionBits);
        found++;
      end
      node_settled[cur] = 1;
      if (found == need) return spre_pkg::ST_OK;
      for (int i = 0; i < graph_edges; i++) begin
        if (graph_src[i] != cur) continue;
        nd = d + graph_len[i];
        if (!node_seen[graph_dst[i]]) begin
          node_seen[graph_dst[i]] = 1;
          path_dist[graph_dst[i]] = nd;
        end else if (!node_settled[graph_dst[i]] && nd < path_dist[graph_dst[i]]) begin
          path_dist[graph_dst[i]] = nd;
        end
      end
    end
    return found == need ? spre_pkg::ST_OK : spre_pkg::ST_MISSING;
  endfunction

  function automatic row_result_t predict_row(spre_pkg::action_t act, logic [7:0] a,
                                              logic [7:0] b, logic [23:0] w);
    row_result_t r;
    r.status = spre_pkg::ST_OK;
    r.distance = '0;
    r.written = 1'b0;
    case (act)
      spre_pkg::ACT_ADD:  r.status = store_edge(a, b, w);
      spre_pkg::ACT_SRCH: r.status = search_rows(a);
      spre_pkg::ACT_READ: begin
        if (node_settled[b]) begin
          r.distance = dist_row[b];
          r.written = 1'b1;
        end
      end
      default: ;
    endcase
    return r;
  endfunction

  // Send one word after a random gap, then predict its result.
  task automatic send_word(spre_pkg::action_t act, logic [7:0] a, logic [7:0] b,
                           logic [23:0] w);
    int gap;
    gap = (quiet || $urandom_range(0, 2) == 0) ? 0 : $urandom_range(0, 16);
    @(negedge clk);
    repeat (gap) begin
      s_tvalid <= 1'b0;
      @(negedge clk);
    end
    s_tvalid <= 1'b1;
    s_tdata <= {6'd0, w, b, a, act};
    do @(posedge clk); while (!s_tready);
    pending_rows.push_back(predict_row(act, a, b, w));
  endtask

  task automatic write_reg(logic [2:0] addr, logic [31:0] value);
    @(negedge clk);
    s_tvalid <= 1'b0;
    psel <= 1'b1;
    pwrite <= 1'b1;
    paddr <= addr;
    pwdata <= value;
    @(negedge clk);
    penable <= 1'b1;
    do @(posedge clk); while (!pready);
    if (addr == spre_pkg::ADDR_POINT_COUNT) point_count = value[8:0];
    else if (addr == spre_pkg::ADDR_NARROW) narrow = value[0];
    @(negedge clk);
    psel <= 1'b0;
    penable <= 1'b0;
  endtask

  // Hold until every result is back and the engine has settled.
  task automatic drain();
    @(negedge clk);
    s_tvalid <= 1'b0;
    wait (pending_rows.size() == 0);
    repeat (20) @(posedge clk);
  endtask

  function automatic logic [7:0] pick_node();
    return ($urandom_range(0, 4) == 0) ? 8'($urandom_range(0, 255)) : 8'($urandom_range(0, 11));
  endfunction

  function automatic logic [23:0] pick_weight();
    case ($urandom_range(0, 5))
      0:       return 24'($urandom);
      1:       return 24'($urandom_range(1040000, 1050000));
      default: return 24'($urandom_range(0, 300));
    endcase
  endfunction

  task automatic test_reset_reads();
    send_word(spre_pkg::ACT_READ, 8'd0, 8'd0, 24'd0);
    send_word(spre_pkg::ACT_READ, 8'd255, 8'd255, 24'hFFFFFF);
    send_word(spre_pkg::ACT_NONE, 8'd255, 8'd255, 24'hFFFFFF);
  endtask

  task automatic test_small_graph();
    send_word(spre_pkg::ACT_ADD, 8'd0, 8'd1, 24'h000010);
    send_word(spre_pkg::ACT_ADD, 8'd0, 8'd1, 24'h000018);   // overwrite, 1.5 rounds up
    send_word(spre_pkg::ACT_ADD, 8'd1, 8'd2, 24'h000007);
    send_word(spre_pkg::ACT_ADD, 8'd0, 8'd2, 24'h000030);
    send_word(spre_pkg::ACT_ADD, 8'd2, 8'd2, 24'h000000);   // self loop
    send_word(spre_pkg::ACT_ADD, 8'd2, 8'd255, 24'hFFFFFF);
    send_word(spre_pkg::ACT_ADD, 8'd3, 8'd0, 24'h000001);   // node 3 unreachable from 0
    send_word(spre_pkg::ACT_SRCH, 8'd0, 8'd0, 24'd0);       // misses 3, which stays unwritten
    for (int n = 0; n < 4; n++) send_word(spre_pkg::ACT_READ, 8'd0, 8'(n), 24'd0);
    send_word(spre_pkg::ACT_READ, 8'd0, 8'd255, 24'd0);
    send_word(spre_pkg::ACT_ADD, 8'd255, 8'd3, 24'h000000);
    send_word(spre_pkg::ACT_SRCH, 8'd0, 8'd0, 24'd0);
    send_word(spre_pkg::ACT_READ, 8'd0, 8'd3, 24'd0);
  endtask

  task automatic test_registers();
    drain();
    write_reg(spre_pkg::ADDR_POINT_COUNT, 32'd1);
    send_word(spre_pkg::ACT_SRCH, 8'd5, 8'd0, 24'd0);       // start not a point
    send_word(spre_pkg::ACT_READ, 8'd0, 8'd3, 24'd0);       // previous search survives
    send_word(spre_pkg::ACT_SRCH, 8'd0, 8'd0, 24'd0);
    send_word(spre_pkg::ACT_READ, 8'd0, 8'd1, 24'd0);
    drain();
    write_reg(spre_pkg::ADDR_POINT_COUNT, 32'd256);
    write_reg(spre_pkg::ADDR_NARROW, 32'd1);
    send_word(spre_pkg::ACT_SRCH, 8'd0, 8'd0, 24'd0);       // node 255 overflows 16 bits
    send_word(spre_pkg::ACT_READ, 8'd0, 8'd2, 24'd0);
    send_word(spre_pkg::ACT_READ, 8'd0, 8'd255, 24'd0);
    drain();
    write_reg(spre_pkg::ADDR_NARROW, 32'd0);
  endtask

  task automatic test_random_traffic();
    int pick;
    logic [31:0] pc_val;
    for (int phase = 0; phase < 4; phase++) begin
      drain();
      case ($urandom_range(0, 2))
        0:       pc_val = 32'd1;
        1:       pc_val = 32'd256;
        default: pc_val = 32'($urandom_range(1, 256));
      endcase
      write_reg(spre_pkg::ADDR_POINT_COUNT, pc_val);
      write_reg(spre_pkg::ADDR_NARROW, 32'($urandom_range(0, 1)));
      quiet = (phase == 2);
      for (int i = 0; i < 17; i++) begin
        pick = $urandom_range(0, 19);
        if (pick < 8)
          send_word(spre_pkg::ACT_ADD, pick_node(), pick_node(), pick_weight());
        else if (pick < 12)
          send_word(spre_pkg::ACT_SRCH, ($urandom_range(0, 3) == 0) ? pick_node() : 8'd0,
                    8'($urandom), 24'($urandom));
        else if (pick < 19)
          send_word(spre_pkg::ACT_READ, 8'($urandom), pick_node(), 24'($urandom));
        else
          send_word(spre_pkg::ACT_NONE, 8'($urandom), 8'($urandom), 24'($urandom));
      end
      quiet = 0;
    end
  endtask

  task automatic test_backpressure();
    drain();
    recv_hold = 400;
    quiet = 1;
    for (int i = 0; i < 8; i++) send_word(spre_pkg::ACT_READ, 8'd0, 8'(i), 24'd0);
    quiet = 0;
  endtask

  // Receiver: random stalls per word, plus a long hold when asked.
  always @(negedge clk) begin
    if (recv_hold > 0) begin
      m_tready <= 1'b0;
      recv_hold--;
    end else if (recv_stall > 0 && !quiet) begin
      m_tready <= 1'b0;
      recv_stall--;
    end else begin
      m_tready <= 1'b1;
    end
  end

  // Compare each result word with the oldest prediction.
  always @(posedge clk) begin
    row_result_t want;
    if (!rst && m_tvalid && m_tready) begin
      recv_stall = ($urandom_range(0, 2) == 0) ? 0 : $urandom_range(0, 16);
      if (pending_rows.size() == 0) begin
        $error("result word with no prediction: %h", m_tdata);
        failures++;
      end else begin
        want = pending_rows.pop_front();
        if (m_tdata[2:0] !== want.status) begin
          $error("status: expected %0d, got %0d", want.status, m_tdata[2:0]);
          failures++;
        end
        if (m_tdata[34:3] !== want.distance) begin
          $error("distance: expected %0d, got %0d", want.distance, m_tdata[34:3]);
          failures++;
        end
        if (m_tdata[35] !== want.written) begin
          $error("written: expected %0d, got %0d", want.written, m_tdata[35]);
          failures++;
        end
      end
    end
  end

  // Watchdog: count cycles without any handshake.
  always @(posedge clk) begin
    if (rst || (s_tvalid && s_tready) || (m_tvalid && m_tready) || (psel && penable))
      idle_cycles <= 0;
    else
      idle_cycles <= idle_cycles + 1;
    if (idle_cycles >= IdleLimit) begin
      $display("CHECKS FAILED");
      $finish;
    end
  end

  initial begin
    rst = 1'b1;
    s_tvalid = 1'b0;
    s_tdata = '0;
    m_tready = 1'b0;
    psel = 1'b0;
    penable = 1'b0;
    pwrite = 1'b0;
    paddr = '0;
    pwdata = '0;
    failures = 0;
    quiet = 0;
    recv_stall = 0;
    recv_hold = 0;
    idle_cycles = 0;
    graph_edges = 0;
    point_count = 256;
    narrow = 0;
    for (int n = 0; n < spre_pkg::MaxNodes; n++) begin
      node_seen[n] = 0;
      node_settled[n] = 0;
    end
    repeat (4) @(posedge clk);
    @(negedge clk);
    rst = 1'b0;

    test_reset_reads();
    test_small_graph();
    test_registers();
    test_random_traffic();
    test_backpressure();

    drain();
    repeat (50) @(posedge clk);
    if (failures == 0) begin
      $display("ALL CHECKS PASSED");
    end else begin
      $display("CHECKS FAILED");
    end
    $finish;
  end

endmodule

[sim.f]
hdl/spre_pkg.sv
hdl/spre_ram.sv
hdl/shortest_path_row_engine.sv
bench/tb_shortest_path_row_engine.sv
